// ===== hw/rtl/pmsd_pkg.sv =====
package pmsd_pkg;

  // Parameter defaults
  localparam int unsigned SUM_WIDTH_DEF      = 32;
  localparam int unsigned POSITION_SHIFT_DEF = 5;

  // Integral is taken in 16-bit slices of the running sum
  localparam int unsigned CHUNK_W = 16;

  // Shared multiplier: signed A x signed B
  localparam int unsigned MUL_A_W = 29;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // 1311/65536 approximates the 20 ms tick; derivative scaled by 50
  localparam logic signed [MUL_B_W-1:0] TICK_NUM    = 17'sd1311;
  localparam logic signed [MUL_B_W-1:0] DERIV_SCALE = 17'sd50;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CAP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_DEADBAND = 3'd5;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic signed [15:0] deriv_gain;
    logic [7:0]         speed_cap;
    logic [7:0]         speed_floor;
    logic [7:0]         integ_deadband;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RST = '{
    prop_gain:      16'sd896,
    integ_gain:     16'sd0,
    deriv_gain:     16'sd0,
    speed_cap:      8'd200,
    speed_floor:    8'd50,
    integ_deadband: 8'd10
  };

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_req_t;

  typedef struct packed {
    logic signed [15:0] rotation_count;
    logic [7:0]         target_position;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         speed;
    logic               direction;
    logic signed [15:0] control_value;
    logic [7:0]         position;
  } out_item_t;

  typedef enum logic [2:0] {
    MUL_IG_TICK,
    MUL_KP_E,
    MUL_DIFF_SCALE,
    MUL_KD_DERIV,
    MUL_G_CHUNK
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD_G,
    ACC_SET,
    ACC_ADD,
    ACC_ISHADD,
    ACC_IADD
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    logic     calc_pos;
    logic     upd_sum;
    logic     calc_ctrl;
    logic     load_out;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/pmsd_chan_if.sv =====
interface pmsd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pmsd_cfg.sv =====
module pmsd_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  pmsd_chan_if.sink           cfg_i,
  output pmsd_pkg::cfg_regs_t regs_o
);

  pmsd_pkg::cfg_regs_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= pmsd_pkg::CFG_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        pmsd_pkg::REG_PROP_GAIN: begin
          regs_q.prop_gain <= signed'(cfg_i.data.wdata);
        end
        pmsd_pkg::REG_INTEG_GAIN: begin
          regs_q.integ_gain <= signed'(cfg_i.data.wdata);
        end
        pmsd_pkg::REG_DERIV_GAIN: begin
          regs_q.deriv_gain <= signed'(cfg_i.data.wdata);
        end
        pmsd_pkg::REG_SPEED_CAP: begin
          regs_q.speed_cap <= cfg_i.data.wdata[7:0];
        end
        pmsd_pkg::REG_SPEED_FLOOR: begin
          regs_q.speed_floor <= cfg_i.data.wdata[7:0];
        end
        pmsd_pkg::REG_INTEG_DEADBAND: begin
          regs_q.integ_deadband <= cfg_i.data.wdata[7:0];
        end
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pmsd_ctrl.sv =====
module pmsd_ctrl #(
  parameter int unsigned SumWidth = pmsd_pkg::SUM_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pmsd_pkg::dp_cmd_t   cmd_o,
  output logic [((((SumWidth + pmsd_pkg::CHUNK_W - 1) / pmsd_pkg::CHUNK_W) > 1) ?
                 $clog2((SumWidth + pmsd_pkg::CHUNK_W - 1) / pmsd_pkg::CHUNK_W) : 1)-1:0]
                              chunk_idx_o
);

  localparam int unsigned NChunk    = (SumWidth + pmsd_pkg::CHUNK_W - 1) / pmsd_pkg::CHUNK_W;
  localparam int unsigned ChunkIdxW = (NChunk > 1) ? $clog2(NChunk) : 1;
  localparam logic [ChunkIdxW-1:0] ChunkTop = ChunkIdxW'(NChunk - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_POS  = 4'd1;
  localparam logic [3:0] ST_SUM  = 4'd2;
  localparam logic [3:0] ST_DIFF = 4'd3;
  localparam logic [3:0] ST_KD   = 4'd4;
  localparam logic [3:0] ST_INT  = 4'd5;
  localparam logic [3:0] ST_IFIN = 4'd6;
  localparam logic [3:0] ST_IADD = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]           state_q, state_d;
  logic [ChunkIdxW-1:0] chunk_q, chunk_d;
  logic                 out_valid_q, out_valid_d;
  pmsd_pkg::dp_cmd_t    cmd;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;
  assign chunk_idx_o = chunk_q;

  always_comb begin
    state_d = state_q;
    chunk_d = chunk_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_POS;
        end
      end
      ST_POS: begin
        cmd.calc_pos = 1'b1;
        cmd.mul_sel  = pmsd_pkg::MUL_IG_TICK;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd.upd_sum = 1'b1;
        cmd.mul_sel = pmsd_pkg::MUL_KP_E;
        cmd.acc_op  = pmsd_pkg::ACC_LOAD_G;
        state_d     = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.mul_sel = pmsd_pkg::MUL_DIFF_SCALE;
        cmd.acc_op  = pmsd_pkg::ACC_SET;
        state_d     = ST_KD;
      end
      ST_KD: begin
        cmd.mul_sel = pmsd_pkg::MUL_KD_DERIV;
        chunk_d     = ChunkTop;
        state_d     = ST_INT;
      end
      ST_INT: begin
        // first pass folds in the derivative product, then the slices
        cmd.mul_sel = pmsd_pkg::MUL_G_CHUNK;
        cmd.acc_op  = (chunk_q == ChunkTop) ? pmsd_pkg::ACC_ADD : pmsd_pkg::ACC_ISHADD;
        if (chunk_q == '0) begin
          state_d = ST_IFIN;
        end else begin
          chunk_d = chunk_q - 1'b1;
        end
      end
      ST_IFIN: begin
        cmd.acc_op = pmsd_pkg::ACC_ISHADD;
        state_d    = ST_IADD;
      end
      ST_IADD: begin
        cmd.acc_op = pmsd_pkg::ACC_IADD;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd.calc_ctrl = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while still waiting");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_POS))
    else $error("accepted request did not start processing");

  a_chunk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INT) |-> (chunk_q <= ChunkTop))
    else $error("integral slice index out of range");

  a_no_early_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> (state_q == ST_OUT && !in_ready_o))
    else $error("control value step not followed by output step");

endmodule

// ===== hw/rtl/pmsd_dp.sv =====
module pmsd_dp #(
  parameter int unsigned SumWidth      = pmsd_pkg::SUM_WIDTH_DEF,
  parameter int unsigned PositionShift = pmsd_pkg::POSITION_SHIFT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pmsd_pkg::dp_cmd_t    cmd_i,
  input  logic [((((SumWidth + pmsd_pkg::CHUNK_W - 1) / pmsd_pkg::CHUNK_W) > 1) ?
                 $clog2((SumWidth + pmsd_pkg::CHUNK_W - 1) / pmsd_pkg::CHUNK_W) : 1)-1:0]
                               chunk_idx_i,
  input  pmsd_pkg::in_item_t   in_item_i,
  input  pmsd_pkg::cfg_regs_t  regs_i,
  output pmsd_pkg::out_item_t  out_item_o
);

  localparam int unsigned CW        = pmsd_pkg::CHUNK_W;
  localparam int unsigned NChunk    = (SumWidth + CW - 1) / CW;
  localparam int unsigned ChunkIdxW = (NChunk > 1) ? $clog2(NChunk) : 1;
  localparam int unsigned SumPadW   = NChunk * CW;
  localparam int unsigned IaccW     = SumWidth + 27;
  localparam int unsigned ITermW    = IaccW - CW;
  localparam int unsigned AccW      = ((ITermW > 32) ? ITermW : 32) + 2;
  localparam int unsigned AW        = pmsd_pkg::MUL_A_W;
  localparam int unsigned BW        = pmsd_pkg::MUL_B_W;
  localparam int unsigned PW        = pmsd_pkg::MUL_P_W;

  localparam logic [ChunkIdxW-1:0]    ChunkTop = ChunkIdxW'(NChunk - 1);
  localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
  localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};
  localparam logic signed [AccW-1:0]  CtrlMax  = AccW'(32767);
  localparam logic signed [AccW-1:0]  CtrlMin  = AccW'(-32768);
  localparam logic signed [AccW-1:0]  DivBias  = AccW'(255);

  logic signed [15:0]         count_q;
  logic [7:0]                 target_q;
  logic [7:0]                 pos_q, pos_d;
  logic signed [9:0]          err_q, err_d;
  logic signed [9:0]          last_err_q;
  logic signed [10:0]         diff_q, diff_d;
  logic signed [SumWidth-1:0] sum_q, sum_d;
  logic signed [PW-1:0]       mul_q, mul_d;
  logic signed [AW-1:0]       g_q;
  logic signed [IaccW-1:0]    iacc_q;
  logic signed [AccW-1:0]     acc_q;
  logic signed [15:0]         ctrl_q, ctrl_d;
  pmsd_pkg::out_item_t        out_q, out_d;

  // position and error
  logic signed [15:0] shifted;
  assign shifted = count_q >>> PositionShift;

  always_comb begin
    if (count_q[15]) begin
      pos_d = 8'd0;
    end else if (shifted > 16'sd255) begin
      pos_d = 8'd255;
    end else begin
      pos_d = shifted[7:0];
    end
  end

  assign err_d = signed'({2'b00, target_q}) - signed'({2'b00, pos_d});

  // integral update with deadband and saturation
  logic [9:0]               err_mag;
  logic signed [SumWidth:0] err_sx;
  logic signed [SumWidth:0] sum_add;

  assign err_mag = err_q[9] ? 10'(-err_q) : err_q;
  assign err_sx  = {{(SumWidth-9){err_q[9]}}, err_q};
  assign sum_add = {sum_q[SumWidth-1], sum_q} + err_sx;

  always_comb begin
    if (err_mag < {2'b00, regs_i.integ_deadband}) begin
      sum_d = '0;
    end else if (sum_add[SumWidth] != sum_add[SumWidth-1]) begin
      sum_d = sum_add[SumWidth] ? SumMin : SumMax;
    end else begin
      sum_d = sum_add[SumWidth-1:0];
    end
  end

  assign diff_d = {err_q[9], err_q} - {last_err_q[9], last_err_q};

  // shared multiplier
  logic signed [SumPadW-1:0] sum_pad;
  logic [CW-1:0]             chunk;
  logic signed [AW-1:0]      mul_a;
  logic signed [BW-1:0]      mul_b;

  assign sum_pad = SumPadW'(sum_q);
  assign chunk   = sum_pad[CW*chunk_idx_i +: CW];

  always_comb begin
    case (cmd_i.mul_sel)
      pmsd_pkg::MUL_IG_TICK: begin
        mul_a = {{(AW-16){regs_i.integ_gain[15]}}, regs_i.integ_gain};
        mul_b = pmsd_pkg::TICK_NUM;
      end
      pmsd_pkg::MUL_KP_E: begin
        mul_a = {{(AW-16){regs_i.prop_gain[15]}}, regs_i.prop_gain};
        mul_b = {{(BW-10){err_q[9]}}, err_q};
      end
      pmsd_pkg::MUL_DIFF_SCALE: begin
        mul_a = {{(AW-11){diff_q[10]}}, diff_q};
        mul_b = pmsd_pkg::DERIV_SCALE;
      end
      pmsd_pkg::MUL_KD_DERIV: begin
        mul_a = {{(AW-16){regs_i.deriv_gain[15]}}, regs_i.deriv_gain};
        mul_b = {mul_q[15], mul_q[15:0]};
      end
      pmsd_pkg::MUL_G_CHUNK: begin
        // top slice carries the sign, lower slices are unsigned
        mul_a = g_q;
        mul_b = (chunk_idx_i == ChunkTop) ? {chunk[CW-1], chunk} : {1'b0, chunk};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_d = mul_a * mul_b;

  // divide by 256 toward zero, then clamp to int16
  logic signed [AccW-1:0] acc_adj, quo;
  assign acc_adj = acc_q[AccW-1] ? acc_q + DivBias : acc_q;
  assign quo     = acc_adj >>> 8;

  always_comb begin
    if (quo > CtrlMax) begin
      ctrl_d = 16'sh7fff;
    end else if (quo < CtrlMin) begin
      ctrl_d = 16'sh8000;
    end else begin
      ctrl_d = quo[15:0];
    end
  end

  // speed shaping
  logic [16:0] ctrl_mag;
  logic [7:0]  spd_cap;

  assign ctrl_mag = ctrl_q[15] ? 17'(-{ctrl_q[15], ctrl_q}) : {1'b0, ctrl_q};
  assign spd_cap  = (ctrl_mag < {9'd0, regs_i.speed_cap}) ? ctrl_mag[7:0] : regs_i.speed_cap;

  always_comb begin
    out_d.direction     = ctrl_q[15];
    out_d.control_value = ctrl_q;
    out_d.position      = pos_q;
    if (ctrl_q < signed'({8'd0, regs_i.speed_floor})) begin
      out_d.speed = regs_i.speed_floor;
    end else if (err_q[9] || (err_q == 10'sd0)) begin
      out_d.speed = 8'd0;
    end else begin
      out_d.speed = spd_cap;
    end
  end

  assign out_item_o = out_q;

  // controller state carried between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      last_err_q <= '0;
    end else if (cmd_i.upd_sum) begin
      sum_q      <= sum_d;
      last_err_q <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    if (cmd_i.load_in) begin
      count_q  <= in_item_i.rotation_count;
      target_q <= in_item_i.target_position;
    end
    if (cmd_i.calc_pos) begin
      pos_q <= pos_d;
      err_q <= err_d;
    end
    if (cmd_i.upd_sum) begin
      diff_q <= diff_d;
    end
    case (cmd_i.acc_op)
      pmsd_pkg::ACC_LOAD_G: begin
        g_q <= mul_q[AW-1:0];
      end
      pmsd_pkg::ACC_SET: begin
        acc_q  <= AccW'(mul_q);
        iacc_q <= '0;
      end
      pmsd_pkg::ACC_ADD: begin
        acc_q <= acc_q + AccW'(mul_q);
      end
      pmsd_pkg::ACC_ISHADD: begin
        iacc_q <= (iacc_q <<< CW) + IaccW'(mul_q);
      end
      pmsd_pkg::ACC_IADD: begin
        acc_q <= acc_q + AccW'(iacc_q >>> CW);
      end
      default: begin
        // hold
      end
    endcase
    if (cmd_i.calc_ctrl) begin
      ctrl_q <= ctrl_d;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== hw/rtl/pid_motor_speed_direction.sv =====
// PID position loop that turns an encoder count into motor speed and direction.
// in_i carries a request of rotation_count and target_position; out_o returns
// speed, direction, control_value and the scaled position used for the error.
// cfg_i writes the gains, speed limits and integral deadband by index; it is
// always ready and must only be used while no request is in flight.
// Requests are handled one at a time: a new request is taken in the cycle after
// the result of the last one is loaded into the output register. The rate is
// set by the single shared 29x17 multiplier, which forms every product in turn,
// and by the integral product taken in 16-bit slices of the sum. The result sits
// in an output register; the next request is accepted while it waits. If the
// receiver stalls, the following result holds in the datapath until the register
// frees up. Reset clears the integral sum and the previous error, and loads the
// register defaults.
module pid_motor_speed_direction #(
  parameter int unsigned SumWidth      = pmsd_pkg::SUM_WIDTH_DEF,
  parameter int unsigned PositionShift = pmsd_pkg::POSITION_SHIFT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pmsd_chan_if.sink   in_i,
  pmsd_chan_if.sink   cfg_i,
  pmsd_chan_if.source out_o
);

  localparam int unsigned NChunk    = (SumWidth + pmsd_pkg::CHUNK_W - 1) / pmsd_pkg::CHUNK_W;
  localparam int unsigned ChunkIdxW = (NChunk > 1) ? $clog2(NChunk) : 1;

  pmsd_pkg::cfg_regs_t  regs;
  pmsd_pkg::dp_cmd_t    cmd;
  logic [ChunkIdxW-1:0] chunk_idx;
  pmsd_pkg::out_item_t  out_item;

  pmsd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  pmsd_ctrl #(
    .SumWidth (SumWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .chunk_idx_o (chunk_idx)
  );

  pmsd_dp #(
    .SumWidth      (SumWidth),
    .PositionShift (PositionShift)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .chunk_idx_i (chunk_idx),
    .in_item_i   (in_i.data),
    .regs_i      (regs),
    .out_item_o  (out_item)
  );

  assign out_o.data = out_item;

endmodule
